// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the table RTL.
// Each macro takes a label, clock, reset and the checked expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/tbl_pkg.sv =====
// Package for the timed block list table: commands, item token, defaults.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none
package tbl_pkg;

   localparam int TBL_ENTRIES = 16;
   localparam logic [15:0] HOLD_TIME_RST = 16'd5000;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // item walking down the cell chain; data is hold time for add, elapsed for tick
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] char_id;
      logic [15:0] data;
      logic        hit;
      logic        placed;
   } tok_type;

endpackage
`default_nettype wire

// ===== hdl/tbl_req_if.sv =====
// Request channel: command, identifier and elapsed time with valid/ready.
// Depends on tbl_pkg.
`default_nettype none
interface tbl_req_if import tbl_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] char_id;
   logic [15:0] elapsed;

   modport source (output valid, command, char_id, elapsed, input ready);
   modport sink   (input valid, command, char_id, elapsed, output ready);
endinterface
`default_nettype wire

// ===== hdl/tbl_rsp_if.sv =====
// Response channel: query hit and add-dropped flags with valid/ready.
// Depends on tbl_pkg.
`default_nettype none
interface tbl_rsp_if import tbl_pkg::*; ();
   logic valid;
   logic ready;
   logic is_blocked;
   logic add_dropped;

   modport source (output valid, is_blocked, add_dropped, input ready);
   modport sink   (input valid, is_blocked, add_dropped, output ready);
endinterface
`default_nettype wire

// ===== hdl/timed_block_list_table.sv =====
// Timed block list table: ENTRIES cells in a chain, each holding one identifier
// with a millisecond countdown. An item enters the first cell when accepted and
// moves one cell per cycle; each cell adds, matches, counts down or clears as it
// passes, the result being registered after the item leaves the last cell, and one item is
// in flight at a time. A new item is accepted once the previous one has left the
// chain and its result is taken (in the same cycle it is taken). hold_time is
// written through csr_wr_en/csr_wr_data and resets to 5000.
`default_nettype none
`include "assert_macros.svh"
module timed_block_list_table import tbl_pkg::*; #(
   parameter int ENTRIES = TBL_ENTRIES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tbl_req_if.sink          req_bus,
   tbl_rsp_if.source        rsp_bus,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] hold_ff, hold_in;
   logic        rsp_vld_ff, rsp_vld_in;
   logic        blocked_ff, blocked_in;
   logic        dropped_ff, dropped_in;
   logic        req_acc;
   cmd_type     req_cmd;

   logic             tok_vld [ENTRIES+1];
   tok_type          tok     [ENTRIES+1];
   logic [ENTRIES-1:0] stage_vld;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_vld_ff || rsp_bus.ready);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign req_cmd       = cmd_type'(req_bus.command);

   assign tok_vld[0]     = req_acc;
   assign tok[0].cmd     = req_cmd;
   assign tok[0].char_id = req_bus.char_id;
   assign tok[0].data    = (req_cmd == CMD_ADD) ? hold_ff : req_bus.elapsed;
   assign tok[0].hit     = 1'b0;
   assign tok[0].placed  = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      tbl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_vld_i (tok_vld[i]),
         .tok_i     (tok[i]),
         .tok_vld_o (tok_vld[i+1]),
         .tok_o     (tok[i+1])
      );
      assign stage_vld[i] = tok_vld[i+1];
   end

   always_comb begin
      hold_in    = csr_wr_en ? csr_wr_data : hold_ff;
      rsp_vld_in = rsp_vld_ff;
      blocked_in = blocked_ff;
      dropped_in = dropped_ff;
      state_in   = state_ff;
      if (tok_vld[ENTRIES]) begin
         rsp_vld_in = 1'b1;
         blocked_in = (tok[ENTRIES].cmd == CMD_QUERY) && tok[ENTRIES].hit;
         dropped_in = (tok[ENTRIES].cmd == CMD_ADD) && !tok[ENTRIES].placed;
      end else if (rsp_vld_ff && rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (tok_vld[ENTRIES]) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         hold_ff    <= HOLD_TIME_RST;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         hold_ff    <= hold_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      blocked_ff <= blocked_in;
      dropped_ff <= dropped_in;
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.is_blocked  = blocked_ff;
   assign rsp_bus.add_dropped = dropped_ff;

   `ASSERT_ALWAYS(a_one_in_flight, clock, reset, $countones(stage_vld) <= 1)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_acc, state_ff == ST_BUSY)
   `ASSERT_IMPLIES(a_exit_when_busy, clock, reset, tok_vld[ENTRIES], state_ff == ST_BUSY)
   `ASSERT_ALWAYS(a_no_rsp_while_busy, clock, reset, !(rsp_vld_ff && (state_ff == ST_BUSY)))

endmodule
`default_nettype wire

// ===== hdl/tbl_cell.sv =====
// One table entry: valid bit, identifier and countdown, plus a token stage.
// Acts on the item passing through and hands it to the next cell. Uses tbl_pkg.
`default_nettype none
module tbl_cell import tbl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    tok_vld_i,
   input  wire tok_type tok_i,
   output logic         tok_vld_o,
   output tok_type      tok_o
);

   logic        ent_vld_ff, ent_vld_in;
   logic [31:0] ent_id_ff, ent_id_in;
   logic [15:0] ent_tmr_ff, ent_tmr_in;
   logic        tok_vld_ff;
   tok_type     tok_ff, tok_in;

   always_comb begin
      ent_vld_in = ent_vld_ff;
      ent_id_in  = ent_id_ff;
      ent_tmr_in = ent_tmr_ff;
      tok_in     = tok_i;
      if (tok_vld_i) begin
         case (tok_i.cmd)
            CMD_ADD: begin
               if (!tok_i.placed && !ent_vld_ff) begin
                  ent_vld_in    = 1'b1;
                  ent_id_in     = tok_i.char_id;
                  ent_tmr_in    = tok_i.data;
                  tok_in.placed = 1'b1;
               end
            end
            CMD_QUERY: begin
               if (ent_vld_ff && (ent_id_ff == tok_i.char_id)) tok_in.hit = 1'b1;
            end
            CMD_TICK: begin
               if (ent_vld_ff) begin
                  if (ent_tmr_ff < tok_i.data) ent_vld_in = 1'b0;
                  else ent_tmr_in = ent_tmr_ff - tok_i.data;
               end
            end
            CMD_CLEAR: begin
               ent_vld_in = 1'b0;
            end
            default: begin
               ent_vld_in = ent_vld_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
         tok_vld_ff <= 1'b0;
      end else begin
         ent_vld_ff <= ent_vld_in;
         tok_vld_ff <= tok_vld_i;
      end
   end

   always_ff @(posedge clock) begin
      ent_id_ff  <= ent_id_in;
      ent_tmr_ff <= ent_tmr_in;
      tok_ff     <= tok_in;
   end

   assign tok_vld_o = tok_vld_ff;
   assign tok_o     = tok_ff;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for timed_block_list_table: queued add/query/tick/clear items,
// an in-bench copy of the aging table that predicts each response, random stalls.
// Depends on tbl_pkg, tbl_req_if, tbl_rsp_if and the RTL top level.
module testbench;
   import tbl_pkg::*;

   localparam int CYCLE_LIMIT = 250000;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] char_id;
      logic [15:0] elapsed;
   } table_cmd_type;

   typedef struct packed {
      logic is_blocked;
      logic add_dropped;
   } table_rsp_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   tbl_req_if req_bus ();
   tbl_rsp_if rsp_bus ();

   timed_block_list_table uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // predicted table contents
   logic        blk_valid [TBL_ENTRIES];
   logic [31:0] blk_id    [TBL_ENTRIES];
   logic [15:0] blk_timer [TBL_ENTRIES];
   logic [15:0] hold_cfg = HOLD_TIME_RST;

   table_cmd_type pending_q [$];
   table_rsp_type expect_q  [$];
   logic [31:0]   id_pool   [6];

   int queued_count   = 0;
   int accepted_count = 0;
   int result_count   = 0;
   int error_count    = 0;
   int hit_count      = 0;
   int drop_count     = 0;
   int tick_count     = 0;
   int clear_count    = 0;
   int hold_writes    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   bit req_taken      = 1'b0;

   task automatic report_error(string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic table_rsp_type apply_command(table_cmd_type it);
      table_rsp_type r;
      int slot;
      r = '0;
      slot = -1;
      case (it.cmd)
         CMD_ADD: begin
            for (int i = 0; i < TBL_ENTRIES; i++)
               if (slot < 0 && !blk_valid[i]) slot = i;
            if (slot < 0) begin
               r.add_dropped = 1'b1;
            end else begin
               blk_valid[slot] = 1'b1;
               blk_id[slot]    = it.char_id;
               blk_timer[slot] = hold_cfg;
            end
         end
         CMD_QUERY: begin
            for (int i = 0; i < TBL_ENTRIES; i++)
               if (blk_valid[i] && blk_id[i] == it.char_id) r.is_blocked = 1'b1;
         end
         CMD_TICK: begin
            for (int i = 0; i < TBL_ENTRIES; i++) begin
               if (blk_valid[i]) begin
                  if (blk_timer[i] < it.elapsed) blk_valid[i] = 1'b0;
                  else blk_timer[i] = blk_timer[i] - it.elapsed;
               end
            end
         end
         default: begin
            for (int i = 0; i < TBL_ENTRIES; i++) blk_valid[i] = 1'b0;
         end
      endcase
      return r;
   endfunction

   // acceptance: predict at the edge the item is taken
   always @(posedge clock) begin : accept_side
      table_cmd_type seen;
      table_rsp_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen.cmd     = cmd_type'(req_bus.command);
         seen.char_id = req_bus.char_id;
         seen.elapsed = req_bus.elapsed;
         want = apply_command(seen);
         expect_q = {expect_q, want};
         accepted_count++;
         req_taken = 1'b1;
         if (want.is_blocked) hit_count++;
         if (want.add_dropped) drop_count++;
         if (seen.cmd == CMD_TICK) tick_count++;
         if (seen.cmd == CMD_CLEAR) clear_count++;
      end
   end

   // driver
   always @(negedge clock) begin : req_driver
      table_cmd_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_q.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.command <= nxt.cmd;
            req_bus.char_id <= nxt.char_id;
            req_bus.elapsed <= nxt.elapsed;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      table_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         result_count++;
         if (expect_q.size() == 0) begin
            report_error("response with no item outstanding");
         end else begin
            want = expect_q.pop_front();
            if (rsp_bus.is_blocked !== want.is_blocked)
               report_error($sformatf("is_blocked got %b, expected %b",
                                      rsp_bus.is_blocked, want.is_blocked));
            if (rsp_bus.add_dropped !== want.add_dropped)
               report_error($sformatf("add_dropped got %b, expected %b",
                                      rsp_bus.add_dropped, want.add_dropped));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("timed_block_list_table test failed");
         $finish;
      end
   end

   task automatic push_cmd(cmd_type c, logic [31:0] id, logic [15:0] el);
      table_cmd_type it;
      it.cmd     = c;
      it.char_id = id;
      it.elapsed = el;
      pending_q = {pending_q, it};
      queued_count++;
   endtask

   function automatic logic [31:0] pick_id();
      if ($urandom_range(99) < 75) return id_pool[$urandom_range(5)];
      return $urandom;
   endfunction

   function automatic logic [15:0] pick_elapsed();
      case ($urandom_range(9))
         0, 1, 2, 3: return 16'($urandom_range(64));
         4, 5:       return 16'($urandom_range(hold_cfg >> 2));
         6:          return hold_cfg;
         7:          return 16'd0;
         8:          return 16'hFFFF;
         default:    return 16'($urandom);
      endcase
   endfunction

   task automatic gen_traffic(int n);
      int made;
      int kind;
      int burst;
      logic [31:0] id;
      made = 0;
      foreach (id_pool[k]) id_pool[k] = (k < 2) ? $urandom_range(15) : $urandom;
      while (made < n) begin
         kind = $urandom_range(99);
         if (kind < 15) begin
            // run of adds to fill the table
            burst = $urandom_range(4, 18);
            repeat (burst) push_cmd(CMD_ADD, pick_id(), 16'($urandom));
            made += burst;
         end else if (kind < 35) begin
            // add, age, probe
            id = pick_id();
            push_cmd(CMD_ADD, id, 16'($urandom));
            push_cmd(CMD_TICK, $urandom, pick_elapsed());
            push_cmd(CMD_QUERY, id, 16'($urandom));
            made += 3;
         end else if (kind < 38) begin
            push_cmd(CMD_CLEAR, $urandom, 16'($urandom));
            made++;
         end else begin
            kind = $urandom_range(99);
            if (kind < 30) push_cmd(CMD_ADD, pick_id(), 16'($urandom));
            else if (kind < 70) push_cmd(CMD_QUERY, pick_id(), 16'($urandom));
            else push_cmd(CMD_TICK, $urandom, pick_elapsed());
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || expect_q.size() != 0) @(negedge clock);
      repeat (TBL_ENTRIES + 4) @(negedge clock);
   endtask

   task automatic write_hold(logic [15:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      hold_cfg    = v;
      hold_writes++;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [15:0] holds [6];
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_ADD;
      req_bus.char_id   = '0;
      req_bus.elapsed   = '0;
      rsp_bus.ready     = 1'b0;
      foreach (blk_valid[i]) begin
         blk_valid[i] = 1'b0;
         blk_id[i]    = '0;
         blk_timer[i] = '0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      recv_idle_pct = 69;

      // directed, reset hold time
      push_cmd(CMD_QUERY, 32'h0, 16'($urandom));
      push_cmd(CMD_ADD, 32'hFFFF_FFFF, 16'($urandom));
      push_cmd(CMD_ADD, 32'h0, 16'($urandom));
      push_cmd(CMD_ADD, 32'h0, 16'($urandom));
      for (int k = 1; k <= 13; k++) push_cmd(CMD_ADD, k, 16'($urandom));
      push_cmd(CMD_ADD, 32'h5555_AAAA, 16'($urandom));
      push_cmd(CMD_QUERY, 32'hFFFF_FFFF, 16'($urandom));
      push_cmd(CMD_QUERY, 32'h5555_AAAA, 16'($urandom));
      // timers land exactly on zero and stay valid until an FFFF tick expires them
      push_cmd(CMD_TICK, $urandom, HOLD_TIME_RST);
      push_cmd(CMD_QUERY, 32'h0, 16'($urandom));
      push_cmd(CMD_TICK, $urandom, 16'd0);
      push_cmd(CMD_TICK, $urandom, 16'hFFFF);
      push_cmd(CMD_QUERY, 32'h0, 16'($urandom));
      push_cmd(CMD_ADD, 32'd7, 16'($urandom));
      push_cmd(CMD_CLEAR, $urandom, 16'($urandom));
      push_cmd(CMD_QUERY, 32'd7, 16'($urandom));
      wait_drained();

      holds = '{16'd0, 16'hFFFF, 16'd250, 16'($urandom_range(2, 65534)), 16'd1,
                HOLD_TIME_RST};
      for (int p = 0; p < 6; p++) begin
         if (p < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 69;
         end else if (p < 4) begin
            send_idle_pct = 69;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_hold(holds[p]);
         gen_traffic(90);
         wait_drained();
      end

      if (expect_q.size() != 0)
         report_error($sformatf("%0d responses never arrived", expect_q.size()));
      $display("Checked %0d responses for %0d items over %0d hold_time writes.",
               result_count, accepted_count, hold_writes);
      $display("Query hits %0d, dropped adds %0d, ticks %0d, clears %0d, errors %0d.",
               hit_count, drop_count, tick_count, clear_count, error_count);
      if (error_count == 0)
         $display("timed_block_list_table test passed");
      else
         $display("timed_block_list_table test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tbl_pkg.sv
hdl/tbl_req_if.sv
hdl/tbl_rsp_if.sv
hdl/tbl_cell.sv
hdl/timed_block_list_table.sv
tb/testbench.sv
